// ===== src/mts_pkg.sv =====
// Shared types, constants and value conversion functions for the max-tracking stack.
// Used by the controller, the datapath and the top level; depends on nothing.
package mts_pkg;

  // Sizing of the stack and of its stored values.
  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;

  // Maximum tree: one registered level per halving of the slot row.
  localparam int LEVELS      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TREE_LEAVES = 1 << LEVELS;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = LEVELS;
  localparam int SET_W       = $clog2(LEVELS + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  // Opcodes of an input item.
  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_TOP      = 3'd2,
    OP_PEEK_MAX = 3'd3,
    OP_POP_MAX  = 3'd4
  } op_t;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef struct packed {
    op_t                opcode;
    logic signed [31:0] push_value;
  } cmd_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    stat_t              status;
  } rsp_item_t;

  // Stack updates the controller can request.
  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_REMOVE
  } stk_op_t;

  // Source of the returned value.
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ECHO,
    RES_TOP,
    RES_MAX
  } res_sel_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic     load_item;
    stk_op_t  stk_op;
    res_sel_t res_sel;
    stat_t    res_status;
    logic     load_result;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_t  opcode;
    logic empty;
    logic full;
    logic max_ready;
  } dp_status_t;

  // A pushed value is kept in the low VALUE_WIDTH bits, sign-extended when wider.
  function automatic value_t to_entry(logic signed [31:0] v);
    return VALUE_WIDTH'(v);
  endfunction

  // A stored value is returned sign-extended, then cut to 32 bits.
  function automatic logic signed [31:0] to_result(value_t e);
    return 32'(e);
  endfunction

endpackage

// ===== src/mts_ctrl.sv =====
// Controller of the max-tracking stack: takes an item, waits for the maximum tree
// when needed, then commands one stack update and a result load. Uses mts_pkg.
module mts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  mts_pkg::dp_status_t dp_status,
  output mts_pkg::ctl_cmd_t   ctl
);
  import mts_pkg::*;

  ctl_state_t state, state_next;
  logic       rsp_valid_next;
  logic       out_free;
  logic       need_tree;
  logic       go;
  stk_op_t    stk_op;
  res_sel_t   res_sel;
  stat_t      res_status;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Decode of the held item into a stack update and a result.
  always_comb begin
    stk_op     = STK_HOLD;
    res_sel    = RES_ZERO;
    res_status = STAT_OK;
    need_tree  = 1'b0;
    unique case (dp_status.opcode)
      OP_PUSH: begin
        if (dp_status.full) begin
          res_status = STAT_FULL;
        end else begin
          stk_op  = STK_PUSH;
          res_sel = RES_ECHO;
        end
      end
      OP_POP, OP_TOP: begin
        if (dp_status.empty) begin
          res_status = STAT_EMPTY;
        end else begin
          stk_op  = (dp_status.opcode == OP_POP) ? STK_POP : STK_HOLD;
          res_sel = RES_TOP;
        end
      end
      OP_PEEK_MAX, OP_POP_MAX: begin
        if (dp_status.empty) begin
          res_status = STAT_EMPTY;
        end else begin
          stk_op    = (dp_status.opcode == OP_POP_MAX) ? STK_REMOVE : STK_HOLD;
          res_sel   = RES_MAX;
          need_tree = 1'b1;
        end
      end
      default: begin
        // Unused opcodes change nothing and report zero with status ok.
        res_status = STAT_OK;
      end
    endcase
  end

  // Next state and commands.
  always_comb begin
    out_free       = !rsp_valid || !rsp_stall;
    go             = out_free && (!need_tree || dp_status.max_ready);
    state_next     = state;
    rsp_valid_next = rsp_valid && rsp_stall;
    cmd_stall      = 1'b1;
    ctl.load_item   = 1'b0;
    ctl.stk_op      = STK_HOLD;
    ctl.res_sel     = res_sel;
    ctl.res_status  = res_status;
    ctl.load_result = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          ctl.load_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          ctl.stk_op      = stk_op;
          ctl.load_result = 1'b1;
          rsp_valid_next  = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/mts_datapath.sv =====
// Datapath of the max-tracking stack: shifting slot row (top at slot 0), entry
// count, registered maximum tree, item and result registers. Uses mts_pkg.
module mts_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mts_pkg::cmd_item_t  cmd,
  input  mts_pkg::ctl_cmd_t   ctl,
  output mts_pkg::dp_status_t dp_status,
  output mts_pkg::rsp_item_t  rsp
);
  import mts_pkg::*;

  localparam int NODES = 2 * TREE_LEAVES - 1;
  localparam int INNER = TREE_LEAVES - 1;

  cmd_item_t        item;
  rsp_item_t        result;
  value_t           slot [STACK_DEPTH];
  value_t           entry_new;
  logic [CNT_W-1:0] count;
  logic [SET_W-1:0] settle;

  // Tree nodes in heap order; inner nodes are registers, leaves come from the slots.
  value_t           nd_val [NODES];
  logic [IDX_W-1:0] nd_idx [NODES];
  logic             nd_vld [NODES];
  value_t           tr_val [INNER];
  logic [IDX_W-1:0] tr_idx [INNER];
  logic             tr_vld [INNER];

  // Held input item.
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item <= cmd;
    end
  end

  assign entry_new = to_entry(item.push_value);

  // Slot row: push shifts down, pop shifts up, remove closes the gap at the maximum.
  for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_slot
    always_ff @(posedge clk) begin
      case (ctl.stk_op)
        STK_PUSH: begin
          if (j == 0) begin
            slot[j] <= entry_new;
          end else begin
            slot[j] <= slot[(j == 0) ? 0 : j - 1];
          end
        end
        STK_POP: begin
          if (j < STACK_DEPTH - 1) begin
            slot[j] <= slot[(j < STACK_DEPTH - 1) ? j + 1 : j];
          end
        end
        STK_REMOVE: begin
          if (j < STACK_DEPTH - 1 && IDX_W'(j) >= tr_idx[0]) begin
            slot[j] <= slot[(j < STACK_DEPTH - 1) ? j + 1 : j];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Entry count and settle counter of the maximum tree.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      settle <= '0;
    end else begin
      case (ctl.stk_op)
        STK_PUSH:               count <= count + CNT_W'(1);
        STK_POP, STK_REMOVE:    count <= count - CNT_W'(1);
        default:                count <= count;
      endcase
      if (ctl.stk_op != STK_HOLD) begin
        settle <= '0;
      end else if (settle != SET_W'(LEVELS)) begin
        settle <= settle + SET_W'(1);
      end
    end
  end

  // Leaves: slots below the count are candidates, padding leaves never win.
  for (genvar j = 0; j < TREE_LEAVES; j++) begin : g_leaf
    if (j < STACK_DEPTH) begin : g_used
      assign nd_val[INNER + j] = slot[j];
      assign nd_vld[INNER + j] = (count > CNT_W'(j));
    end else begin : g_pad
      assign nd_val[INNER + j] = '0;
      assign nd_vld[INNER + j] = 1'b0;
    end
    assign nd_idx[INNER + j] = IDX_W'(j);
  end

  // Inner nodes: the left child is nearer the top and wins ties.
  for (genvar k = 0; k < INNER; k++) begin : g_node
    logic take_left;
    assign take_left = nd_vld[2*k+1] &&
                       (!nd_vld[2*k+2] || (nd_val[2*k+1] >= nd_val[2*k+2]));
    always_ff @(posedge clk) begin
      tr_vld[k] <= nd_vld[2*k+1] || nd_vld[2*k+2];
      tr_val[k] <= take_left ? nd_val[2*k+1] : nd_val[2*k+2];
      tr_idx[k] <= take_left ? nd_idx[2*k+1] : nd_idx[2*k+2];
    end
    assign nd_val[k] = tr_val[k];
    assign nd_idx[k] = tr_idx[k];
    assign nd_vld[k] = tr_vld[k];
  end

  // Result register: the echoed push value, the top slot or the tree maximum, as they stand before the update.
  always_ff @(posedge clk) begin
    if (ctl.load_result) begin
      result.status <= ctl.res_status;
      case (ctl.res_sel)
        RES_ECHO: result.result_value <= to_result(entry_new);
        RES_TOP:  result.result_value <= to_result(slot[0]);
        RES_MAX:  result.result_value <= to_result(tr_val[0]);
        default:  result.result_value <= '0;
      endcase
    end
  end

  assign rsp                 = result;
  assign dp_status.opcode    = item.opcode;
  assign dp_status.empty     = (count == '0);
  assign dp_status.full      = (count == CNT_W'(STACK_DEPTH));
  assign dp_status.max_ready = (settle == SET_W'(LEVELS));

endmodule

// ===== src/max_tracking_stack.sv =====
// Top level of the max-tracking stack: joins the controller and the datapath.
// Depends on mts_pkg, mts_ctrl and mts_datapath.
//
// Usage: the command channel (cmd_valid, cmd_stall, cmd) carries an opcode and a
// push value; the response channel (rsp_valid, rsp_stall, rsp) returns one result
// per command, in order. A transfer happens at a clock edge with valid high and
// stall low. The block takes a command, executes it in the next cycle or later,
// and places the result in an output register; a new command is taken in the
// cycle after execution, even while that result still waits.
// Push, pop, top and unused opcodes execute once the output is free. Peek max and
// pop max read a registered maximum tree of LEVELS = clog2(STACK_DEPTH) levels
// (4 at depth 16) and wait until it has settled after the stack last changed.
// Synchronous reset empties the stack and drops any pending result; stored
// values are not cleared. While the receiver stalls a waiting result, the block
// accepts at most one more command and holds it, not yet executed, until the
// output frees.
module max_tracking_stack (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  mts_pkg::cmd_item_t cmd,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output mts_pkg::rsp_item_t rsp
);
  import mts_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t dp_status;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .dp_status (dp_status),
    .ctl       (ctl)
  );

  mts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .dp_status (dp_status),
    .rsp       (rsp)
  );

endmodule

// ===== sim/max_tracking_stack_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for max_tracking_stack: random and directed stack commands.
// Depends on mts_pkg and the max_tracking_stack RTL; the expected results come from
// a behavioral stack kept inside this file.
module max_tracking_stack_tb;
  import mts_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 11;
  localparam int TARGET_OPS   = 1100;
  localparam int REPORT_LIMIT = 10;
  localparam int SETTLE_WAIT  = 4 * LEVELS + 20;
  localparam logic [2:0] FIRST_UNUSED_OP = 3'(OP_POP_MAX) + 3'd1;

  // A queued command; drain_first holds it back until every result is in.
  typedef struct {
    cmd_item_t item;
    bit        drain_first;
  } pending_cmd_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  cmd_item_t  cmd = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_item_t  rsp;

  // Behavioral copy of the stack.
  value_t     stk_vals [STACK_DEPTH];
  int         stk_count = 0;

  pending_cmd_t pending_cmds [$];
  rsp_item_t    expected_rsps [$];
  int           mismatch_count = 0;
  int           stack_ops_queued = 0;

  // Sender pacing.
  int         burst_left = 0;
  int         gap_left = 0;

  // Receiver stall pattern.
  int         stall_mode = 0;
  int         stall_phase_left = 0;
  rsp_item_t  want_rsp;

  max_tracking_stack DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Apply one command to the behavioral stack and return the result it should give.
  function automatic rsp_item_t apply_stack_op(cmd_item_t c);
    rsp_item_t r;
    int        max_idx;
    r.result_value = '0;
    r.status       = STAT_OK;
    case (c.opcode)
      OP_PUSH: begin
        if (stk_count >= STACK_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          stk_vals[stk_count] = VALUE_WIDTH'(c.push_value);
          r.result_value = 32'(stk_vals[stk_count]);
          stk_count++;
        end
      end
      OP_POP, OP_TOP: begin
        if (stk_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.result_value = 32'(stk_vals[stk_count - 1]);
          if (c.opcode == OP_POP) stk_count--;
        end
      end
      OP_PEEK_MAX, OP_POP_MAX: begin
        if (stk_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // Ties go to the copy nearest the top.
          max_idx = 0;
          for (int i = 1; i < stk_count; i++)
            if (stk_vals[i] >= stk_vals[max_idx]) max_idx = i;
          r.result_value = 32'(stk_vals[max_idx]);
          if (c.opcode == OP_POP_MAX) begin
            for (int i = max_idx; i < stk_count - 1; i++) stk_vals[i] = stk_vals[i + 1];
            stk_count--;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Values lean toward the extremes and a narrow band that produces ties.
  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3, 4: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t unused_op();
    return op_t'(FIRST_UNUSED_OP + 3'($urandom_range(0, 2)));
  endfunction

  task automatic queue_cmd(op_t op, logic signed [31:0] value, bit drain_first = 1'b0);
    pending_cmd_t p;
    p.item.opcode     = op;
    p.item.push_value = value;
    p.drain_first     = drain_first;
    pending_cmds.insert(pending_cmds.size(), p);
    if (op <= OP_POP_MAX) stack_ops_queued++;
  endtask

  // Driver: predicts each accepted transfer and presents the next command in bursts.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd       <= '0;
    end else begin
      if (cmd_valid && !cmd_stall)
        expected_rsps.insert(expected_rsps.size(), apply_stack_op(cmd));
      if (!cmd_valid || !cmd_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain_first && expected_rsps.size() > 0)) begin
          cmd       <= pending_cmds[0].item;
          cmd_valid <= 1'b1;
          pending_cmds[0].drain_first = 1'b0;
          void'(pending_cmds.pop_front());
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Mostly short bursts, now and then a long stretch with no gaps.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result with nothing pending: value %0d status %0d",
                     $time, rsp.result_value, rsp.status);
        end else begin
          want_rsp = expected_rsps.pop_front();
          if (rsp.result_value !== want_rsp.result_value || rsp.status !== want_rsp.status)
          begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: mismatch: value want %0d got %0d, status want %0d got %0d",
                       $time, want_rsp.result_value, rsp.result_value,
                       want_rsp.status, rsp.status);
          end
        end
      end

      // The stall pattern switches between free flow, light, heavy and long stalls.
      if (stall_phase_left == 0) begin
        stall_mode       = $urandom_range(0, 3);
        stall_phase_left = $urandom_range(20, 200);
      end else begin
        stall_phase_left--;
      end
      case (stall_mode)
        0:       rsp_stall <= 1'b0;
        1:       rsp_stall <= ($urandom_range(0, 3) == 0);
        2:       rsp_stall <= ($urandom_range(0, 3) != 0);
        default: rsp_stall <= ((stall_phase_left % 16) < 10);
      endcase
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int phase;
    int run_len;
    int pick;
    op_t op;

    // Directed: empty-stack errors, unused opcodes, extreme values and ties.
    queue_cmd(OP_POP, $urandom);
    queue_cmd(OP_TOP, $urandom);
    queue_cmd(OP_PEEK_MAX, $urandom);
    queue_cmd(OP_POP_MAX, $urandom);
    queue_cmd(op_t'(FIRST_UNUSED_OP), $urandom);
    queue_cmd(op_t'(FIRST_UNUSED_OP + 3'd1), $urandom);
    queue_cmd(op_t'(FIRST_UNUSED_OP + 3'd2), $urandom);
    queue_cmd(OP_PUSH, 32'sh7FFF_FFFF);
    queue_cmd(OP_PUSH, 32'sh8000_0000);
    queue_cmd(OP_PUSH, 32'sh7FFF_FFFF);
    queue_cmd(OP_PUSH, -32'sd1);
    queue_cmd(OP_PUSH, 32'sd0);
    queue_cmd(unused_op(), $urandom);
    queue_cmd(OP_PEEK_MAX, $urandom);
    queue_cmd(OP_POP_MAX, $urandom);
    queue_cmd(OP_TOP, $urandom);
    queue_cmd(OP_POP_MAX, $urandom);
    queue_cmd(OP_PEEK_MAX, $urandom);
    queue_cmd(OP_POP, $urandom);
    queue_cmd(OP_POP, $urandom);
    queue_cmd(OP_TOP, $urandom);
    queue_cmd(OP_POP_MAX, $urandom);
    queue_cmd(OP_POP, $urandom, 1'b1);

    // Random phases: filling runs lean toward a full stack, draining runs toward empty.
    while (stack_ops_queued < TARGET_OPS) begin
      phase   = $urandom_range(0, 9);
      run_len = $urandom_range(8, 40);
      for (int n = 0; n < run_len; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2 || (phase == 9 && pick < 30)) begin
          op = unused_op();
        end else if (phase <= 2) begin
          op = (pick < 75) ? OP_PUSH : op_t'(3'($urandom_range(1, 4)));
        end else if (phase <= 5) begin
          if (pick < 70)      op = ($urandom_range(0, 1) == 0) ? OP_POP : OP_POP_MAX;
          else if (pick < 85) op = OP_PUSH;
          else                op = ($urandom_range(0, 1) == 0) ? OP_TOP : OP_PEEK_MAX;
        end else begin
          op = op_t'(3'($urandom_range(0, 4)));
        end
        queue_cmd(op, ($urandom_range(0, 3) == 0) ? $urandom : random_value(),
                  (stack_ops_queued % 300) == 299);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || cmd_valid) @(posedge clk);
    while (expected_rsps.size() > 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== max_tracking_stack.f =====
src/mts_pkg.sv
src/mts_ctrl.sv
src/mts_datapath.sv
src/max_tracking_stack.sv
sim/max_tracking_stack_tb.sv
